@@ rtl/ubds_pkg.sv @@
// ubds_pkg: shared types and constants for the uart baud divisor search
// used by ubds_if, ubds_div and uart_baud_divisor_search; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ubds_pkg;

	localparam int BaudW   = 25;
	localparam int ClkW    = 31;
	localparam int OsrW    = 6;
	localparam int SbrW    = 13;
	localparam int ErrW    = 31;
	localparam int DivW    = 32;
	localparam int DivCntW = $clog2(DivW);
	localparam int MulW    = BaudW + OsrW;

	localparam int unsigned SBR_MAX    = 8191;
	localparam int unsigned OSR_FIRST  = 4;
	localparam int unsigned OSR_LAST   = 32;
	localparam int unsigned BOTH_LIMIT = 8;
	localparam int unsigned PCT_DIV    = 100;
	localparam int unsigned CLK_RESET  = 8000000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_DIV1,
		ST_WAIT1,
		ST_SBR,
		ST_MUL2,
		ST_DIV2,
		ST_WAIT2,
		ST_CMP,
		ST_DIV3,
		ST_WAIT3,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic            start;
		logic [DivW-1:0] num;
		logic [DivW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DivW-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/ubds_if.sv @@
// ubds_if: valid/ready channel interfaces for request, result and clock config words
// depends on ubds_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ubds_req_if
	import ubds_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [BaudW-1:0] baud_rate;

	modport source (output valid, output baud_rate, input ready);
	modport sink (input valid, input baud_rate, output ready);
endinterface

interface ubds_rsp_if
	import ubds_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [OsrW-1:0] oversample;
	logic [SbrW-1:0] divisor;
	logic            both_edge;
	logic [ErrW-1:0] baud_error;
	logic            supported;

	modport source (output valid, output oversample, output divisor, output both_edge,
		output baud_error, output supported, input ready);
	modport sink (input valid, input oversample, input divisor, input both_edge,
		input baud_error, input supported, output ready);
endinterface

interface ubds_cfg_if
	import ubds_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [ClkW-1:0] source_clock_hz;

	modport source (output valid, output source_clock_hz, input ready);
	modport sink (input valid, input source_clock_hz, output ready);
endinterface

`default_nettype wire

@@ rtl/uart_baud_divisor_search.sv @@
// uart_baud_divisor_search: best oversampling ratio and baud divisor for a requested rate
// depends on ubds_pkg, ubds_if and ubds_div
//
//  channel  dir   word                                                     handshake
//  req      in    baud_rate                                                valid/ready
//  rsp      out   oversample, divisor, both_edge, baud_error, supported    valid/ready
//  cfg      in    source_clock_hz                                          valid/ready
//
// one request searches 29 ratios and then runs one tail division before it returns to idle
// each ratio runs two divisions on the shared divider
// req.ready is high only while the sequencer is idle; cfg.ready is always high
// the result sits in an output register; a stalled rsp holds only the final hand-off
// reset sets source_clock_hz to 8000000 and clears the sequencer and rsp.valid
`timescale 1ns / 1ps
`default_nettype none

module uart_baud_divisor_search
	import ubds_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	ubds_req_if.sink   req,
	ubds_rsp_if.source rsp,
	ubds_cfg_if.sink   cfg
);

	state_t            state_q;
	state_t            state_d;
	logic [ClkW-1:0]   clk_hz_q;
	logic [BaudW-1:0]  baud_q;
	logic [OsrW-1:0]   osr_q;
	logic [SbrW-1:0]   sbr_q;
	logic [MulW-1:0]   mul_q;
	logic [DivW-1:0]   best_err_q;
	logic [OsrW-1:0]   best_osr_q;
	logic [SbrW-1:0]   best_sbr_q;
	logic [DivW-1:0]   pct_q;
	logic              rsp_valid_q;
	logic [OsrW-1:0]   rsp_osr_q;
	logic [SbrW-1:0]   rsp_sbr_q;
	logic              rsp_both_q;
	logic [ErrW-1:0]   rsp_err_q;
	logic              rsp_sup_q;

	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic              load_rsp;
	logic [BaudW-1:0]  mul_a;
	logic [DivW:0]     half;
	logic [SbrW-1:0]   sbr_new;
	logic [DivW-1:0]   err;
	logic [DivW-1:0]   baud_ext;
	logic [DivW+1:0]   tol;

	ubds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign baud_ext = DivW'(baud_q);
	assign mul_a    = (state_q == ST_MUL1) ? baud_q : BaudW'(sbr_q);
	assign half     = ({1'b0, div_rsp.quo} + 1'b1) >> 1;
	assign err      = (div_rsp.quo > baud_ext) ? (div_rsp.quo - baud_ext)
	                                           : (baud_ext - div_rsp.quo);
	assign tol      = {2'b00, pct_q} + {1'b0, pct_q, 1'b0};

	always_comb begin
		if (div_rsp.quo == '0) begin
			sbr_new = SbrW'(1);
		end else if (half > (DivW + 1)'(SBR_MAX)) begin
			sbr_new = SbrW'(SBR_MAX);
		end else begin
			sbr_new = half[SbrW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clk_hz_q    <= ClkW'(CLK_RESET);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				clk_hz_q <= cfg.source_clock_hz;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		req.ready     = 1'b0;
		load_rsp      = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = {clk_hz_q, 1'b0};
		div_req.den   = DivW'(mul_q);
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_DIV1;
			ST_DIV1: begin
				div_req.start = 1'b1;
				state_d       = ST_WAIT1;
			end
			ST_WAIT1: begin
				if (div_rsp.done) begin
					state_d = ST_SBR;
				end
			end
			ST_SBR:  state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DIV2;
			ST_DIV2: begin
				div_req.start = 1'b1;
				div_req.num   = DivW'(clk_hz_q);
				state_d       = ST_WAIT2;
			end
			ST_WAIT2: begin
				if (div_rsp.done) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = (osr_q == OsrW'(OSR_LAST)) ? ST_DIV3 : ST_MUL1;
			end
			ST_DIV3: begin
				div_req.start = 1'b1;
				div_req.num   = baud_ext;
				div_req.den   = DivW'(PCT_DIV);
				state_d       = ST_WAIT3;
			end
			ST_WAIT3: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					baud_q     <= req.baud_rate;
					osr_q      <= OsrW'(OSR_FIRST);
					best_err_q <= DivW'(req.baud_rate);
					best_osr_q <= '0;
					best_sbr_q <= '0;
				end
			end
			ST_MUL1, ST_MUL2: mul_q <= MulW'(mul_a) * MulW'(osr_q);
			ST_SBR: sbr_q <= sbr_new;
			ST_CMP: begin
				if (err <= best_err_q) begin
					best_err_q <= err;
					best_osr_q <= osr_q;
					best_sbr_q <= sbr_q;
				end
				osr_q <= osr_q + 1'b1;
			end
			ST_WAIT3: begin
				if (div_rsp.done) begin
					pct_q <= div_rsp.quo;
				end
			end
			default: begin
			end
		endcase
		if (load_rsp) begin
			rsp_osr_q  <= best_osr_q;
			rsp_sbr_q  <= best_sbr_q;
			rsp_both_q <= (best_osr_q >= OsrW'(OSR_FIRST)) && (best_osr_q < OsrW'(BOTH_LIMIT));
			rsp_err_q  <= best_err_q[ErrW-1:0];
			rsp_sup_q  <= ({2'b00, best_err_q} <= tol);
		end
	end

	assign cfg.ready      = 1'b1;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.oversample = rsp_osr_q;
	assign rsp.divisor    = rsp_sbr_q;
	assign rsp.both_edge  = rsp_both_q;
	assign rsp.baud_error = rsp_err_q;
	assign rsp.supported  = rsp_sup_q;

	a_start_first_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_MUL1 && osr_q == OsrW'(OSR_FIRST)))
		else $error("search did not start at the first ratio");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (osr_q >= OsrW'(OSR_FIRST) && osr_q <= OsrW'(OSR_LAST)))
		else $error("ratio out of range during compare");

	a_sbr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL2) |-> (sbr_q != '0 && sbr_q <= SbrW'(SBR_MAX)))
		else $error("divisor outside 1..max");

	a_none_kept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ((rsp_osr_q == '0) == (rsp_sbr_q == '0)))
		else $error("ratio and divisor disagree on whether a candidate was kept");

	a_both_edge: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_both_q == (rsp_osr_q >= OsrW'(OSR_FIRST)
			&& rsp_osr_q < OsrW'(BOTH_LIMIT))))
		else $error("both-edge flag does not follow the ratio");

endmodule

`default_nettype wire

@@ rtl/ubds_div.sv @@
// ubds_div: shared 32-bit restoring divider, one quotient bit per cycle
// depends on ubds_pkg; a zero divisor gives an all-ones quotient
`timescale 1ns / 1ps
`default_nettype none

module ubds_div
	import ubds_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [DivW-1:0]    rem_q;
	logic [DivW-1:0]    acc_q;
	logic [DivW-1:0]    den_q;
	logic [DivW:0]      shifted;
	logic [DivW:0]      diff;
	logic               qbit;

	assign shifted = {rem_q, acc_q[DivW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign qbit    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DivCntW'(DivW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			acc_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DivW-1:0] : shifted[DivW-1:0];
			acc_q <= {acc_q[DivW-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = acc_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q)
		else $error("divider done while still busy");

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && !busy_q && req.den == '0) |-> ##(DivW + 1) (acc_q == '1))
		else $error("zero divisor did not give all-ones quotient");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for uart_baud_divisor_search
// depends on ubds_pkg, ubds_if and the uart_baud_divisor_search rtl
`timescale 1ns / 1ps

module testbench;
	import ubds_pkg::*;

	localparam int unsigned PCT_TOL = 3;
	localparam int unsigned BAUD_MAX = (1 << BaudW) - 1;
	localparam int unsigned HZ_MAX = 32'h7FFF_FFFF;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES = 2200;
	localparam int PHASE_ITEMS = 75;
	localparam int CLOCK_EVERY = 25;
	localparam int DIR_ROWS = 25;

	typedef struct packed {
		logic [OsrW-1:0] oversample;
		logic [SbrW-1:0] divisor;
		logic            both_edge;
		logic [ErrW-1:0] baud_error;
		logic            supported;
	} fit_t;

	typedef enum logic {OP_CLOCK, OP_BAUD} dir_op_t;

	typedef struct packed {
		dir_op_t     op;
		logic [31:0] value;
		logic        typed;
		fit_t        want;
	} dir_row_t;

	localparam fit_t NO_FIT = '0;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{OP_BAUD, 32'd0, 1'b1, '{6'd0, 13'd0, 1'b0, 31'd0, 1'b1}},
		'{OP_BAUD, 32'd33554431, 1'b1, '{6'd4, 13'd1, 1'b1, 31'd31554431, 1'b0}},
		'{OP_BAUD, 32'd2000000, 1'b1, '{6'd4, 13'd1, 1'b1, 31'd0, 1'b1}},
		'{OP_BAUD, 32'd1, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd9600, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd115200, 1'b0, NO_FIT},
		'{OP_CLOCK, 32'd0, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd0, 1'b1, '{6'd32, 13'd8191, 1'b0, 31'd0, 1'b1}},
		'{OP_BAUD, 32'd115200, 1'b1, '{6'd32, 13'd1, 1'b0, 31'd115200, 1'b0}},
		'{OP_CLOCK, 32'd2147483647, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd1, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd0, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd33554431, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd3000000, 1'b0, NO_FIT},
		'{OP_CLOCK, 32'd1, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd1, 1'b1, '{6'd32, 13'd1, 1'b0, 31'd1, 1'b0}},
		'{OP_BAUD, 32'd33554431, 1'b1, '{6'd32, 13'd1, 1'b0, 31'd33554431, 1'b0}},
		'{OP_CLOCK, 32'd48000000, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd12000000, 1'b1, '{6'd4, 13'd1, 1'b1, 31'd0, 1'b1}},
		'{OP_BAUD, 32'd300, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd1, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd115200, 1'b0, NO_FIT},
		'{OP_CLOCK, 32'd8000000, 1'b0, NO_FIT},
		'{OP_BAUD, 32'd250000, 1'b1, '{6'd32, 13'd1, 1'b0, 31'd0, 1'b1}},
		'{OP_BAUD, 32'd333, 1'b0, NO_FIT}
	};

	localparam int unsigned STD_BAUD [16] = '{300, 1200, 2400, 4800, 9600, 19200, 38400,
		57600, 115200, 230400, 460800, 921600, 1000000, 1500000, 3000000, 4000000};
	localparam int unsigned STD_HZ [8] = '{1843200, 3686400, 8000000, 12000000, 16000000,
		24000000, 48000000, 96000000};
	localparam int unsigned SEND_IDLE [4] = '{0, 84, 0, 15};
	localparam int unsigned RSP_STALL [4] = '{0, 0, 84, 15};

	logic clk = 1'b0;
	logic arst_n;

	ubds_req_if req ();
	ubds_rsp_if rsp ();
	ubds_cfg_if cfg ();

	uart_baud_divisor_search u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	fit_t fit_q [$];
	int unsigned source_hz = CLK_RESET;
	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	int unsigned idle_cycles = 0;
	int errors = 0;

	// best ratio and divisor for one requested rate at the given source clock
	function automatic fit_t best_fit(input int unsigned hz, input int unsigned baud);
		int unsigned clk2, den, quo, sbr, achieved, err;
		int unsigned best_err, best_osr, best_sbr;
		logic [63:0] half;
		fit_t fit;
		clk2 = hz * 2;
		best_err = baud;
		best_osr = 0;
		best_sbr = 0;
		for (int unsigned osr = OSR_FIRST; osr <= OSR_LAST; osr++) begin
			den = baud * osr;
			if (den == 0) begin
				quo = 32'hFFFF_FFFF;
			end else begin
				quo = clk2 / den;
			end
			half = ({32'd0, quo} + 64'd1) >> 1;
			if (half == 0) begin
				sbr = 1;
			end else if (half > SBR_MAX) begin
				sbr = SBR_MAX;
			end else begin
				sbr = half[31:0];
			end
			achieved = hz / (osr * sbr);
			err = (achieved > baud) ? achieved - baud : baud - achieved;
			if (err <= best_err) begin
				best_err = err;
				best_osr = osr;
				best_sbr = sbr;
			end
		end
		fit.oversample = OsrW'(best_osr);
		fit.divisor = SbrW'(best_sbr);
		fit.both_edge = (best_osr >= OSR_FIRST) && (best_osr < BOTH_LIMIT);
		fit.baud_error = ErrW'(best_err);
		fit.supported = best_err <= (baud / PCT_DIV) * PCT_TOL;
		return fit;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic send_baud(input int unsigned baud, input bit typed, input fit_t typed_fit);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.baud_rate <= BaudW'(baud);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		fit_q.push_back(typed ? typed_fit : best_fit(source_hz, baud));
	endtask

	// clock word goes in only once every result is back
	task automatic set_source_clock(input int unsigned hz);
		req.valid <= 1'b0;
		while (fit_q.size() != 0) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.source_clock_hz <= ClkW'(hz);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		source_hz = hz & HZ_MAX;
	endtask

	function automatic int unsigned pick_clock();
		case ($urandom_range(0, 4))
			0, 1: return STD_HZ[$urandom_range(0, 7)];
			2: return $urandom() & HZ_MAX;
			3: return $urandom_range(1, 100000);
			default: return $urandom_range(0, 1) ? HZ_MAX : 1;
		endcase
	endfunction

	function automatic int unsigned pick_baud();
		int unsigned b;
		case ($urandom_range(0, 5))
			0, 1: b = STD_BAUD[$urandom_range(0, 15)];
			2: b = $urandom_range(1, BAUD_MAX);
			3: b = $urandom_range(1, 2000);
			default: b = source_hz / ($urandom_range(4, 32) * $urandom_range(1, 64))
				+ $urandom_range(0, 2);
		endcase
		if (b == 0 || b > BAUD_MAX) begin
			b = $urandom_range(1, BAUD_MAX);
		end
		return b;
	endfunction

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= arst_n && ($urandom_range(0, 99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin : check_word
		fit_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (fit_q.size() == 0) begin
				report_mismatch("unexpected word, oversample", rsp.oversample, 0);
			end else begin
				want = fit_q.pop_front();
				if (rsp.oversample !== want.oversample)
					report_mismatch("oversample", rsp.oversample, want.oversample);
				if (rsp.divisor !== want.divisor)
					report_mismatch("divisor", rsp.divisor, want.divisor);
				if (rsp.both_edge !== want.both_edge)
					report_mismatch("both_edge", rsp.both_edge, want.both_edge);
				if (rsp.baud_error !== want.baud_error)
					report_mismatch("baud_error", rsp.baud_error, want.baud_error);
				if (rsp.supported !== want.supported)
					report_mismatch("supported", rsp.supported, want.supported);
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t row;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.baud_rate <= '0;
		cfg.valid <= 1'b0;
		cfg.source_clock_hz <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.op == OP_CLOCK) begin
				set_source_clock(row.value);
			end else begin
				send_baud(row.value, row.typed, row.want);
			end
		end

		for (int phase = 0; phase < 4; phase++) begin
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % CLOCK_EVERY == 0) begin
					set_source_clock(pick_clock());
					send_idle_pct = SEND_IDLE[phase];
					rsp_stall_pct = RSP_STALL[phase];
				end
				send_baud(pick_baud(), 1'b0, NO_FIT);
			end
		end

		req.valid <= 1'b0;
		while (fit_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/ubds_pkg.sv
rtl/ubds_if.sv
rtl/ubds_div.sv
rtl/uart_baud_divisor_search.sv
tb/testbench.sv
